/* design/ptg_pkg.sv */
package ptg_pkg;

  // Field and register widths.
  localparam int KIND_W    = 2;
  localparam int FREQ_W    = 16;
  localparam int VOL_W     = 8;
  localparam int DUR_W     = 16;
  localparam int CLK_W     = 25;
  localparam int MAXV_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = CLK_W;

  // Waveform counter, period top and duty level width.
  localparam int WAVE_W = 16;

  // Volume table and slow prescaler.
  localparam int VOLUME_STEPS = 10;
  localparam int VIDX_W       = $clog2(VOLUME_STEPS);
  localparam int VDIV_W       = 8;
  localparam int SLOW_DIVIDE  = 256;
  localparam int PRESC_W      = $clog2(SLOW_DIVIDE);

  // Shared divider: one quotient bit per step over the widest dividend.
  localparam int DIV_STEPS = CLK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Reset values of the configuration registers.
  localparam logic [CLK_W-1:0]  CPU_CLOCK_RESET  = CLK_W'(16000000);
  localparam logic [MAXV_W-1:0] MAX_VOLUME_RESET = MAXV_W'(10);
  localparam logic [MAXV_W-1:0] VOLUME_TOP       = MAXV_W'(VOLUME_STEPS);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PLAY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLOCK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MILLI = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CPU_CLOCK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLUME = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic finish_freq;
    logic commit;
    logic silence;
    logic clock_tick;
    logic milli_tick;
    logic load_out;
  } ptg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              play_zero;
    logic              div_done;
    logic              half_zero;
  } ptg_status_t;

  // Duty divisor for each volume step; indexes past the end saturate.
  function automatic logic [VDIV_W-1:0] vol_divisor(input logic [VIDX_W-1:0] idx);
    logic [VDIV_W-1:0] res;
    unique case (idx)
      4'd0:    res = 8'd200;
      4'd1:    res = 8'd100;
      4'd2:    res = 8'd67;
      4'd3:    res = 8'd50;
      4'd4:    res = 8'd40;
      4'd5:    res = 8'd33;
      4'd6:    res = 8'd29;
      4'd7:    res = 8'd22;
      4'd8:    res = 8'd11;
      default: res = 8'd2;
    endcase
    return res;
  endfunction

endpackage

/* design/ptg_if.sv */
// Input word channel.
interface ptg_item_if
  import ptg_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [FREQ_W-1:0] frequency_hz;
  logic [VOL_W-1:0]  volume_level;
  logic [DUR_W-1:0]  duration_ms;

  modport source (output valid, kind, frequency_hz, volume_level, duration_ms,
                  input ready);
  modport sink (input valid, kind, frequency_hz, volume_level, duration_ms,
                output ready);
endinterface

// Result word channel.
interface ptg_result_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic sounding;

  modport source (output valid, pin_a, pin_b, sounding, input ready);
  modport sink (input valid, pin_a, pin_b, sounding, output ready);
endinterface

// Configuration write channel.
interface ptg_cfg_if
  import ptg_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/pwm_tone_generator_unit.sv */
// Ticks, unknown words and plays with zero frequency or volume: one word per
// cycle while the result slot is free or draining; the result word is valid in
// the cycle after acceptance. Other plays: two passes of the shared divider at
// one quotient bit per cycle, then commit (if the frequency is too high, only
// the first, then silence). Reset (async, active low) silences the tone, clears
// all tone state and loads the configuration defaults; there is no clearing pass.
module pwm_tone_generator_unit
  import ptg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ptg_item_if.sink     item_i,
  ptg_result_if.source result_o,
  ptg_cfg_if.sink      cfg_i
);

  ptg_cmd_t    cmd;
  ptg_status_t status;

  // Configuration is taken at any time.
  assign cfg_i.ready = 1'b1;

  ptg_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_i.valid),
    .item_ready_o   (item_i.ready),
    .result_valid_o (result_o.valid),
    .result_ready_i (result_o.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  ptg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (item_i.kind),
    .frequency_hz_i (item_i.frequency_hz),
    .volume_level_i (item_i.volume_level),
    .duration_ms_i  (item_i.duration_ms),
    .cfg_write_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .pin_a_o        (result_o.pin_a),
    .pin_b_o        (result_o.pin_b),
    .sounding_o     (result_o.sounding)
  );

endmodule

/* design/ptg_ctrl.sv */
module ptg_ctrl
  import ptg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  input  ptg_status_t status_i,
  output ptg_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DIV_FREQ = 2'd1;
  localparam logic [1:0] ST_DIV_DUTY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  // A word is taken only when idle and the result slot is free or draining.
  assign item_ready_o   = (state_q == ST_IDLE) && (!out_valid_q || result_ready_i);
  assign accept         = item_valid_i && item_ready_o;
  assign result_valid_o = out_valid_q;

  // Sequencing of words and the two divisions of a play command.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (status_i.kind)
            KIND_PLAY: begin
              if (status_i.play_zero) begin
                cmd_o.silence  = 1'b1;
                cmd_o.load_out = 1'b1;
              end else begin
                cmd_o.capture = 1'b1;
                state_d       = ST_DIV_FREQ;
              end
            end
            KIND_CLOCK: begin
              cmd_o.clock_tick = 1'b1;
              cmd_o.load_out   = 1'b1;
            end
            KIND_MILLI: begin
              cmd_o.milli_tick = 1'b1;
              cmd_o.load_out   = 1'b1;
            end
            default: begin
              cmd_o.load_out = 1'b1;
            end
          endcase
        end
      end
      ST_DIV_FREQ: begin
        if (status_i.div_done) begin
          if (status_i.half_zero) begin
            // Frequency too high: silence without starting the duty division.
            cmd_o.silence  = 1'b1;
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.finish_freq = 1'b1;
            state_d           = ST_DIV_DUTY;
          end
        end
      end
      ST_DIV_DUTY: begin
        if (status_i.div_done) begin
          cmd_o.commit   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result slot occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || result_ready_i))
    else $error("result slot overwritten");

  // A nontrivial play command starts the period division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.kind == KIND_PLAY && !status_i.play_zero)
      |=> (state_q == ST_DIV_FREQ))
    else $error("play command did not start the division");

  // The duty division only follows the period division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DIV_DUTY) |-> ($past(state_q) == ST_DIV_FREQ))
    else $error("duty division entered out of order");
`endif

endmodule

/* design/ptg_dp.sv */
module ptg_dp
  import ptg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptg_cmd_t             cmd_i,
  output ptg_status_t          status_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [FREQ_W-1:0]    frequency_hz_i,
  input  logic [VOL_W-1:0]     volume_level_i,
  input  logic [DUR_W-1:0]     duration_ms_i,
  input  logic                 cfg_write_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 pin_a_o,
  output logic                 pin_b_o,
  output logic                 sounding_o
);

  // Configuration registers.
  logic [CLK_W-1:0]  cpu_clock_q;
  logic [MAXV_W-1:0] max_volume_q;

  // Tone state.
  logic [WAVE_W-1:0]  top_q, top_d;
  logic [WAVE_W-1:0]  duty_q, duty_d;
  logic [WAVE_W-1:0]  wave_q, wave_d;
  logic               down_q, down_d;
  logic               slow_q, slow_d;
  logic [PRESC_W-1:0] presc_q, presc_d;
  logic               active_q, active_d;
  logic               timed_q, timed_d;
  logic [DUR_W-1:0]   remain_q, remain_d;

  // Captured play command and pending period.
  logic [VIDX_W-1:0] vidx_q;
  logic [DUR_W-1:0]  dur_q;
  logic [WAVE_W-1:0] top_pend_q;
  logic              slow_pend_q;

  // Shared restoring divider.
  logic [CLK_W-1:0]     quo_q;
  logic [FREQ_W-1:0]    rem_q;
  logic [FREQ_W-1:0]    dsr_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [FREQ_W:0]      rem_sh;
  logic [FREQ_W:0]      rem_sub;
  logic                 rem_ge;

  // Result word.
  logic pin_a_q, pin_b_q, sounding_q;
  logic res_a;

  // Volume clamp.
  logic [MAXV_W-1:0] vmax;
  logic [MAXV_W-1:0] vol_eff;

  // Period top from the first quotient.
  logic [CLK_W-2:0]  half;
  logic [CLK_W-2:0]  top0;
  logic [CLK_W-2:0]  tslow;
  logic [CLK_W-2:0]  tslow1;
  logic              top_big;
  logic [WAVE_W-1:0] top_next;
  logic [WAVE_W-1:0] top_sat;

  // Clock tick helpers.
  logic [PRESC_W:0]  presc_inc;
  logic              presc_wrap;
  logic              wave_step;

  assign status_o.kind      = kind_i;
  assign status_o.play_zero = (frequency_hz_i == '0) || (volume_level_i == '0);
  assign status_o.div_done  = (div_cnt_q == '0);
  assign status_o.half_zero = (half == '0);

  // Effective volume: level capped at the maximum, kept within one and the table length.
  always_comb begin
    if (max_volume_q == '0) begin
      vmax = MAXV_W'(1);
    end else if (max_volume_q > VOLUME_TOP) begin
      vmax = VOLUME_TOP;
    end else begin
      vmax = max_volume_q;
    end
    if (volume_level_i > VOL_W'(vmax)) begin
      vol_eff = vmax;
    end else begin
      vol_eff = volume_level_i[MAXV_W-1:0];
    end
  end

  // Period top, with the slow prescaler when the fast top does not fit.
  assign half    = quo_q[CLK_W-1:1];
  assign top0    = half - 1'b1;
  assign top_big = |top0[CLK_W-2:WAVE_W];
  assign tslow   = (CLK_W-1)'(top0 / SLOW_DIVIDE);
  assign tslow1  = (tslow != '0) ? tslow - 1'b1 : '0;
  assign top_sat = (|tslow1[CLK_W-2:WAVE_W]) ? '1 : tslow1[WAVE_W-1:0];
  assign top_next = top_big ? top_sat : top0[WAVE_W-1:0];

  // One quotient bit per step.
  assign rem_sh  = {rem_q, quo_q[CLK_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.capture || cmd_i.finish_freq) begin
      div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      quo_q <= cpu_clock_q;
      rem_q <= '0;
      dsr_q <= frequency_hz_i;
    end else if (cmd_i.finish_freq) begin
      quo_q <= CLK_W'(top_next);
      rem_q <= '0;
      dsr_q <= FREQ_W'(vol_divisor(vidx_q));
    end else if (div_cnt_q != '0) begin
      quo_q <= {quo_q[CLK_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
    end
  end

  // Captured fields and the pending period.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vidx_q <= VIDX_W'(vol_eff - 1'b1);
      dur_q  <= duration_ms_i;
    end
    if (cmd_i.finish_freq) begin
      top_pend_q  <= top_next;
      slow_pend_q <= top_big;
    end
  end

  // Next tone state for play, tick and silence commands.
  always_comb begin
    top_d    = top_q;
    duty_d   = duty_q;
    wave_d   = wave_q;
    down_d   = down_q;
    slow_d   = slow_q;
    presc_d  = presc_q;
    active_d = active_q;
    timed_d  = timed_q;
    remain_d = remain_q;

    presc_inc  = {1'b0, presc_q} + 1'b1;
    presc_wrap = presc_inc == (PRESC_W+1)'(SLOW_DIVIDE);
    wave_step  = !slow_q || presc_wrap;

    if (cmd_i.commit) begin
      top_d   = top_pend_q;
      duty_d  = quo_q[WAVE_W-1:0];
      slow_d  = slow_pend_q;
      presc_d = '0;
      timed_d = (dur_q != '0);
      if (dur_q != '0) begin
        remain_d = dur_q;
      end
      if (wave_q > top_pend_q) begin
        wave_d = top_pend_q;
      end
      active_d = 1'b1;
    end

    if (cmd_i.clock_tick && active_q) begin
      if (slow_q) begin
        presc_d = presc_wrap ? '0 : presc_inc[PRESC_W-1:0];
      end
      if (wave_step) begin
        if (!down_q) begin
          if (wave_q < top_q) begin
            wave_d = wave_q + 1'b1;
          end else begin
            down_d = 1'b1;
            if (wave_q != '0) begin
              wave_d = wave_q - 1'b1;
            end
          end
        end else begin
          if (wave_q != '0) begin
            wave_d = wave_q - 1'b1;
          end else begin
            down_d = 1'b0;
            if (top_q != '0) begin
              wave_d = wave_q + 1'b1;
            end
          end
        end
        // Timed stop lands on the first compare match after expiry.
        if ((wave_d == duty_q) && timed_q && (remain_q == '0)) begin
          active_d = 1'b0;
          timed_d  = 1'b0;
        end
      end
    end

    if (cmd_i.milli_tick && active_q && timed_q && (remain_q != '0)) begin
      remain_d = remain_q - 1'b1;
    end

    if (cmd_i.silence) begin
      active_d = 1'b0;
      timed_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      duty_q   <= '0;
      wave_q   <= '0;
      down_q   <= 1'b0;
      slow_q   <= 1'b0;
      presc_q  <= '0;
      active_q <= 1'b0;
      timed_q  <= 1'b0;
      remain_q <= '0;
    end else begin
      top_q    <= top_d;
      duty_q   <= duty_d;
      wave_q   <= wave_d;
      down_q   <= down_d;
      slow_q   <= slow_d;
      presc_q  <= presc_d;
      active_q <= active_d;
      timed_q  <= timed_d;
      remain_q <= remain_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_clock_q  <= CPU_CLOCK_RESET;
      max_volume_q <= MAX_VOLUME_RESET;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        REG_CPU_CLOCK:  cpu_clock_q  <= cfg_data_i;
        REG_MAX_VOLUME: max_volume_q <= cfg_data_i[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  // Result word reflects the state after the word.
  assign res_a = active_d && (wave_d < duty_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pin_a_q    <= res_a;
      pin_b_q    <= active_d && !res_a;
      sounding_q <= active_d;
    end
  end

  assign pin_a_o    = pin_a_q;
  assign pin_b_o    = pin_b_q;
  assign sounding_o = sounding_q;

`ifndef NO_ASSERTIONS
  // The counter never runs past the period top.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_q <= top_q)
    else $error("wave counter above period top");

  // A new division never starts while one is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture || cmd_i.finish_freq) |-> (div_cnt_q == '0))
    else $error("divider restarted while busy");

  // A play is committed only from a finished quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (div_cnt_q == '0))
    else $error("commit before the duty division finished");
`endif

endmodule
